// ===== rtl/tfs_pkg.sv =====
// Shared types, widths and codes for the tile fade and shrink pipeline.
`timescale 1ns / 1ps
`default_nettype none

package tfs_pkg;

   // Defaults for the top-level parameters.
   localparam int GRID_BITS_DEF     = 8;
   localparam int PROGRESS_FRAC_DEF = 16;

   // Fixed field widths.
   localparam int TILE_IDX_W  = 8;
   localparam int PROGRESS_W  = 17;
   localparam int COORD_W     = 24;
   localparam int MODE_W      = 2;
   localparam int GRID_DIM_W  = 9;
   localparam int SUM_W       = GRID_DIM_W + 1;
   localparam int STEP_W      = 23;
   localparam int STATE_W     = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 23;
   localparam int DIST_FRAC   = 16;
   localparam int NUM_CORNERS = 8;

   // Effect modes.
   localparam logic [MODE_W-1:0] MODE_TOP_RIGHT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BOTTOM_LEFT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UP          = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DOWN        = 2'd3;

   // Register indexes of the control port.
   localparam logic [CSR_IDX_W-1:0] CSR_EFFECT_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_X      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_Y      = 3'd4;

   // Result tile states.
   localparam logic [STATE_W-1:0] TILE_OFF      = 2'd0;
   localparam logic [STATE_W-1:0] TILE_SHRUNK   = 2'd1;
   localparam logic [STATE_W-1:0] TILE_ORIGINAL = 2'd2;

   // Corner order is bl_x, bl_y, br_x, br_y, tl_x, tl_y, tr_x, tr_y.
   // A set bit means the offset is subtracted from that coordinate.
   localparam logic [NUM_CORNERS-1:0] CORNER_NEG = 8'b1110_0100;

   localparam logic [DIST_FRAC:0] DIST_ONE = {1'b1, {DIST_FRAC{1'b0}}};

   localparam logic [COORD_W-1:0] COORD_MAX_VAL = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] COORD_MIN_VAL = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic [TILE_IDX_W-1:0]     tile_col;
      logic [TILE_IDX_W-1:0]     tile_row;
      logic [PROGRESS_W-1:0]     progress;
      logic signed [COORD_W-1:0] bl_x;
      logic signed [COORD_W-1:0] bl_y;
      logic signed [COORD_W-1:0] br_x;
      logic signed [COORD_W-1:0] br_y;
      logic signed [COORD_W-1:0] tl_x;
      logic signed [COORD_W-1:0] tl_y;
      logic signed [COORD_W-1:0] tr_x;
      logic signed [COORD_W-1:0] tr_y;
   } tfs_req_type;

   typedef struct packed {
      logic [STATE_W-1:0]        tile_state;
      logic signed [COORD_W-1:0] out_bl_x;
      logic signed [COORD_W-1:0] out_bl_y;
      logic signed [COORD_W-1:0] out_br_x;
      logic signed [COORD_W-1:0] out_br_y;
      logic signed [COORD_W-1:0] out_tl_x;
      logic signed [COORD_W-1:0] out_tl_y;
      logic signed [COORD_W-1:0] out_tr_x;
      logic signed [COORD_W-1:0] out_tr_y;
   } tfs_rsp_type;

   typedef struct packed {
      logic [MODE_W-1:0]     effect_mode;
      logic [GRID_DIM_W-1:0] grid_width;
      logic [GRID_DIM_W-1:0] grid_height;
      logic [STEP_W-1:0]     step_x;
      logic [STEP_W-1:0]     step_y;
   } tfs_cfg_type;

   typedef logic [NUM_CORNERS-1:0][COORD_W-1:0] tfs_corners_type;

   // Per-tile side data that rides along the pipeline.
   typedef struct packed {
      logic [STATE_W-1:0] tile_state;
      logic               y_only;
      tfs_corners_type    corners;
   } tfs_info_type;

endpackage

`default_nettype wire

// ===== rtl/tfs_front.sv =====
// Front stages: ratio numerator and denominator, then tile classification.
`timescale 1ns / 1ps
`default_nettype none

module tfs_front #(
   parameter int GRID_BITS     = tfs_pkg::GRID_BITS_DEF,
   parameter int PROGRESS_FRAC = tfs_pkg::PROGRESS_FRAC_DEF,
   parameter int NUM_W         = tfs_pkg::SUM_W + PROGRESS_FRAC + 1
) (
   input  wire                       clock,
   input  wire                       reset,
   input  tfs_pkg::tfs_cfg_type      cfg,
   input  wire                       in_valid,
   output logic                      in_ready,
   input  tfs_pkg::tfs_req_type      in_data,
   output logic                      out_valid,
   input  wire                       out_ready,
   output logic [NUM_W-1:0]          out_num,
   output logic [NUM_W-1:0]          out_den,
   output tfs_pkg::tfs_info_type     out_info
);
   import tfs_pkg::*;

   localparam int CB = (GRID_BITS < TILE_IDX_W) ? GRID_BITS : TILE_IDX_W;
   localparam int PW = (PROGRESS_FRAC + 1 > PROGRESS_W) ? PROGRESS_FRAC + 1 : PROGRESS_W;
   localparam logic [PROGRESS_FRAC:0] ONE_P = {1'b1, {PROGRESS_FRAC{1'b0}}};

   logic                     s1_valid_ff, s1_valid_in;
   logic [NUM_W-1:0]         s1_num_ff, s1_num_in;
   logic [NUM_W-1:0]         s1_den_ff, s1_den_in;
   tfs_info_type             s1_info_ff, s1_info_in;
   logic                     s2_valid_ff, s2_valid_in;
   logic [NUM_W-1:0]         s2_num_ff, s2_num_in;
   logic [NUM_W-1:0]         s2_den_ff, s2_den_in;
   tfs_info_type             s2_info_ff, s2_info_in;
   logic                     s1_ready, s2_ready;

   logic [CB-1:0]            col_m, row_m;
   logic [CB:0]              pos_sum;
   logic [PW-1:0]            p_ext;
   logic [PROGRESS_FRAC:0]   p_clamp, p_rest;
   logic [SUM_W-1:0]         dim_sum, mult_a;
   logic [PROGRESS_FRAC:0]   mult_b;
   logic [NUM_W-1:0]         prod, shifted;
   logic                     y_only, inverse;
   tfs_info_type             info_c;
   logic [STATE_W-1:0]       state_c;

   // A stage takes a new transfer when it is empty or its content moves on.
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Stage one: one shared multiplier forms the product side of the ratio.
   always_comb begin
      col_m   = in_data.tile_col[CB-1:0];
      row_m   = in_data.tile_row[CB-1:0];
      pos_sum = {1'b0, col_m} + {1'b0, row_m};
      p_ext   = PW'(in_data.progress);
      p_clamp = (p_ext > PW'(ONE_P)) ? ONE_P : p_ext[PROGRESS_FRAC:0];
      p_rest  = ONE_P - p_clamp;
      dim_sum = {1'b0, cfg.grid_width} + {1'b0, cfg.grid_height};
      y_only  = (cfg.effect_mode == MODE_UP) || (cfg.effect_mode == MODE_DOWN);
      inverse = (cfg.effect_mode == MODE_BOTTOM_LEFT) || (cfg.effect_mode == MODE_DOWN);
      mult_a  = y_only ? {1'b0, cfg.grid_height} : dim_sum;
      mult_b  = inverse ? p_rest : p_clamp;
      prod    = NUM_W'(mult_a) * NUM_W'(mult_b);
      shifted = y_only ? (NUM_W'(row_m) << PROGRESS_FRAC) : (NUM_W'(pos_sum) << PROGRESS_FRAC);

      info_c.tile_state = TILE_ORIGINAL;
      info_c.y_only     = y_only;
      info_c.corners[0] = in_data.bl_x;
      info_c.corners[1] = in_data.bl_y;
      info_c.corners[2] = in_data.br_x;
      info_c.corners[3] = in_data.br_y;
      info_c.corners[4] = in_data.tl_x;
      info_c.corners[5] = in_data.tl_y;
      info_c.corners[6] = in_data.tr_x;
      info_c.corners[7] = in_data.tr_y;

      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
      s1_num_in   = s1_num_ff;
      s1_den_in   = s1_den_ff;
      s1_info_in  = s1_info_ff;
      if (s1_ready && in_valid) begin
         s1_num_in  = inverse ? prod : shifted;
         s1_den_in  = inverse ? shifted : prod;
         s1_info_in = info_c;
      end
   end

   // Stage two: exact classification of the ratio against zero and one.
   always_comb begin
      priority if (s1_den_ff == '0) begin
         state_c = TILE_ORIGINAL;
      end else if (s1_num_ff == '0) begin
         state_c = TILE_OFF;
      end else if (s1_num_ff >= s1_den_ff) begin
         state_c = TILE_ORIGINAL;
      end else begin
         state_c = TILE_SHRUNK;
      end

      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      s2_num_in   = s2_num_ff;
      s2_den_in   = s2_den_ff;
      s2_info_in  = s2_info_ff;
      if (s2_ready && s1_valid_ff) begin
         s2_num_in             = s1_num_ff;
         s2_den_in             = s1_den_ff;
         s2_info_in            = s1_info_ff;
         s2_info_in.tile_state = state_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_num_ff  <= s1_num_in;
      s1_den_ff  <= s1_den_in;
      s1_info_ff <= s1_info_in;
      s2_num_ff  <= s2_num_in;
      s2_den_ff  <= s2_den_in;
      s2_info_ff <= s2_info_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_num   = s2_num_ff;
   assign out_den   = s2_den_ff;
   assign out_info  = s2_info_ff;

`ifndef SYNTHESIS
   // A tile marked for shrinking must have a proper fraction as its ratio.
   a_shrunk_ratio_below_one: assert property (@(posedge clock) disable iff (reset)
      out_valid && (out_info.tile_state == TILE_SHRUNK) |-> (out_num < out_den))
      else $error("shrunk tile leaves classification with num >= den");
`endif

endmodule

`default_nettype wire

// ===== rtl/tfs_div_step.sv =====
// One restoring-division stage: produces one quotient bit of the ratio.
`timescale 1ns / 1ps
`default_nettype none

module tfs_div_step #(
   parameter int NUM_W = tfs_pkg::SUM_W + tfs_pkg::PROGRESS_FRAC_DEF + 1
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             in_valid,
   output logic                            in_ready,
   input  wire [NUM_W-1:0]                 in_rem,
   input  wire [NUM_W-1:0]                 in_den,
   input  wire [tfs_pkg::DIST_FRAC-1:0]    in_quo,
   input  tfs_pkg::tfs_info_type           in_info,
   output logic                            out_valid,
   input  wire                             out_ready,
   output logic [NUM_W-1:0]                out_rem,
   output logic [NUM_W-1:0]                out_den,
   output logic [tfs_pkg::DIST_FRAC-1:0]   out_quo,
   output tfs_pkg::tfs_info_type           out_info
);
   import tfs_pkg::*;

   logic                   valid_ff, valid_in;
   logic [NUM_W-1:0]       rem_ff, rem_in;
   logic [NUM_W-1:0]       den_ff, den_in;
   logic [DIST_FRAC-1:0]   quo_ff, quo_in;
   tfs_info_type           info_ff, info_in;
   logic                   ready;
   logic [NUM_W:0]         trial, diff;
   logic                   fits;

   assign ready    = !valid_ff || out_ready;
   assign in_ready = ready;

   // Shift the partial remainder and subtract the divisor where it fits.
   always_comb begin
      trial = {in_rem, 1'b0};
      fits  = trial >= {1'b0, in_den};
      diff  = trial - {1'b0, in_den};

      valid_in = ready ? in_valid : valid_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      info_in  = info_ff;
      if (ready && in_valid) begin
         rem_in  = fits ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
         den_in  = in_den;
         quo_in  = {in_quo[DIST_FRAC-2:0], fits};
         info_in = in_info;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      info_ff <= info_in;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_info  = info_ff;

`ifndef SYNTHESIS
   // For a shrinking tile the partial remainder stays below the divisor.
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      out_valid && (out_info.tile_state == TILE_SHRUNK) |-> (out_rem < out_den))
      else $error("division remainder reached the divisor");
`endif

endmodule

`default_nettype wire

// ===== rtl/tfs_power.sv =====
// Power stages: sixth power of the ratio and the per-axis shrink offsets.
`timescale 1ns / 1ps
`default_nettype none

module tfs_power (
   input  wire                             clock,
   input  wire                             reset,
   input  tfs_pkg::tfs_cfg_type            cfg,
   input  wire                             in_valid,
   output logic                            in_ready,
   input  wire [tfs_pkg::DIST_FRAC-1:0]    in_quo,
   input  tfs_pkg::tfs_info_type           in_info,
   output logic                            out_valid,
   input  wire                             out_ready,
   output logic [tfs_pkg::STEP_W-1:0]      out_ox,
   output logic [tfs_pkg::STEP_W-1:0]      out_oy,
   output tfs_pkg::tfs_info_type           out_info
);
   import tfs_pkg::*;

   localparam int SQ_W = 2 * DIST_FRAC;
   localparam int PX_W = STEP_W + DIST_FRAC + 1;

   logic [3:0]             valid_ff, valid_in;
   logic [3:0]             ready;
   tfs_info_type           info1_ff, info1_in, info2_ff, info2_in;
   tfs_info_type           info3_ff, info3_in, info4_ff, info4_in;
   logic [DIST_FRAC-1:0]   r1_ff, r1_in, r2_ff, r2_in;
   logic [DIST_FRAC-1:0]   r2b_ff, r2b_in, r3_ff, r3_in, d_ff, d_in;
   logic [STEP_W-1:0]      ox_ff, ox_in, oy_ff, oy_in;
   logic [SQ_W-1:0]        sq1, sq2, sq3;
   logic [DIST_FRAC:0]     rest;
   logic [PX_W-1:0]        px, py;

   assign ready[3] = !valid_ff[3] || out_ready;
   assign ready[2] = !valid_ff[2] || ready[3];
   assign ready[1] = !valid_ff[1] || ready[2];
   assign ready[0] = !valid_ff[0] || ready[1];
   assign in_ready = ready[0];

   always_comb begin
      sq1  = SQ_W'(in_quo) * SQ_W'(in_quo);
      sq2  = SQ_W'(r2_ff) * SQ_W'(r1_ff);
      sq3  = SQ_W'(r3_ff) * SQ_W'(r3_ff);
      rest = DIST_ONE - {1'b0, d_ff};
      px   = PX_W'(cfg.step_x) * PX_W'(rest);
      py   = PX_W'(cfg.step_y) * PX_W'(rest);

      valid_in[0] = ready[0] ? in_valid    : valid_ff[0];
      valid_in[1] = ready[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = ready[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = ready[3] ? valid_ff[2] : valid_ff[3];

      // Stage one: square of the ratio.
      r1_in    = r1_ff;
      r2_in    = r2_ff;
      info1_in = info1_ff;
      if (ready[0] && in_valid) begin
         r1_in    = in_quo;
         r2_in    = sq1[SQ_W-1:DIST_FRAC];
         info1_in = in_info;
      end

      // Stage two: cube of the ratio.
      r2b_in   = r2b_ff;
      r3_in    = r3_ff;
      info2_in = info2_ff;
      if (ready[1] && valid_ff[0]) begin
         r2b_in   = r2_ff;
         r3_in    = sq2[SQ_W-1:DIST_FRAC];
         info2_in = info1_ff;
      end

      // Stage three: the distance is the cube squared.
      d_in     = d_ff;
      info3_in = info3_ff;
      if (ready[2] && valid_ff[1]) begin
         d_in     = sq3[SQ_W-1:DIST_FRAC];
         info3_in = info2_ff;
      end

      // Stage four: half a step scaled by one minus the distance.
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      info4_in = info4_ff;
      if (ready[3] && valid_ff[2]) begin
         ox_in    = px[PX_W-1:DIST_FRAC+1];
         oy_in    = py[PX_W-1:DIST_FRAC+1];
         info4_in = info3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      r1_ff    <= r1_in;
      r2_ff    <= r2_in;
      r2b_ff   <= r2b_in;
      r3_ff    <= r3_in;
      d_ff     <= d_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      info1_ff <= info1_in;
      info2_ff <= info2_in;
      info3_ff <= info3_in;
      info4_ff <= info4_in;
   end

   assign out_valid = valid_ff[3];
   assign out_ox    = ox_ff;
   assign out_oy    = oy_ff;
   assign out_info  = info4_ff;

`ifndef SYNTHESIS
   // Powers of a fraction never grow: the cube stays at or below the square.
   a_cube_not_above_square: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (r3_ff <= r2b_ff))
      else $error("cube of the ratio exceeds its square");
`endif

endmodule

`default_nettype wire

// ===== rtl/tfs_apply.sv =====
// Output stage: applies offsets to the corners, saturates and holds the result.
`timescale 1ns / 1ps
`default_nettype none

module tfs_apply (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire [tfs_pkg::STEP_W-1:0]    in_ox,
   input  wire [tfs_pkg::STEP_W-1:0]    in_oy,
   input  tfs_pkg::tfs_info_type        in_info,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output tfs_pkg::tfs_rsp_type         rsp_data
);
   import tfs_pkg::*;

   localparam int EXT_W = COORD_W + 1;

   logic              valid_ff, valid_in;
   tfs_rsp_type       rsp_ff, rsp_in;
   logic              ready;
   tfs_corners_type   result;
   logic [STEP_W-1:0] ox_eff, off;
   logic [EXT_W-1:0]  ext, moved;

   assign ready    = !valid_ff || !rsp_stall;
   assign in_ready = ready;

   // A shrunk tile's coordinates move by their axis offset and saturate to 24 bits; others are zeroed or kept.
   always_comb begin
      ox_eff = in_info.y_only ? '0 : in_ox;
      result = '0;
      ext    = '0;
      off    = '0;
      moved  = '0;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         off = (i % 2 == 0) ? ox_eff : in_oy;
         ext = {in_info.corners[i][COORD_W-1], in_info.corners[i]};
         if (CORNER_NEG[i]) begin
            moved = ext - EXT_W'(off);
         end else begin
            moved = ext + EXT_W'(off);
         end
         if (in_info.tile_state == TILE_OFF) begin
            result[i] = '0;
         end else if (in_info.tile_state != TILE_SHRUNK) begin
            result[i] = in_info.corners[i];
         end else if (moved[EXT_W-1] != moved[EXT_W-2]) begin
            result[i] = moved[EXT_W-1] ? COORD_MIN_VAL : COORD_MAX_VAL;
         end else begin
            result[i] = moved[COORD_W-1:0];
         end
      end

      valid_in = ready ? in_valid : valid_ff;
      rsp_in   = rsp_ff;
      if (ready && in_valid) begin
         rsp_in.tile_state = in_info.tile_state;
         rsp_in.out_bl_x   = result[0];
         rsp_in.out_bl_y   = result[1];
         rsp_in.out_br_x   = result[2];
         rsp_in.out_br_y   = result[3];
         rsp_in.out_tl_x   = result[4];
         rsp_in.out_tl_y   = result[5];
         rsp_in.out_tr_x   = result[6];
         rsp_in.out_tr_y   = result[7];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // A tile that is turned off carries only zero corners.
   a_off_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.tile_state == TILE_OFF) |->
      ((rsp_data.out_bl_x | rsp_data.out_bl_y | rsp_data.out_br_x | rsp_data.out_br_y |
        rsp_data.out_tl_x | rsp_data.out_tl_y | rsp_data.out_tr_x | rsp_data.out_tr_y) == '0))
      else $error("turned-off tile has nonzero corners");
`endif

endmodule

`default_nettype wire

// ===== rtl/tile_fade_shrink.sv =====
// Throughput: one tile per cycle while the receiver does not stall; each of the 23 register
// stages fills a bubble on its own, so the ratio divider, which spends one stage on each of its
// 16 quotient bits, sets the depth and the output register sets nothing but the final hold.
// Reset is synchronous: all valid bits clear and the registers return to mode 0,
// a 1 by 1 grid and zero steps; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module tile_fade_shrink #(
   parameter int GRID_BITS     = tfs_pkg::GRID_BITS_DEF,
   parameter int PROGRESS_FRAC = tfs_pkg::PROGRESS_FRAC_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  tfs_pkg::tfs_req_type             req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output tfs_pkg::tfs_rsp_type             rsp_data,
   input  wire                              csr_write_en,
   input  wire [tfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [tfs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tfs_pkg::*;

   localparam int NUM_W = SUM_W + PROGRESS_FRAC + 1;

   tfs_cfg_type          cfg_ff, cfg_in;
   logic                 front_ready;
   logic [DIST_FRAC:0]   dv_valid, dv_ready;
   logic [NUM_W-1:0]     dv_rem [0:DIST_FRAC];
   logic [NUM_W-1:0]     dv_den [0:DIST_FRAC];
   logic [DIST_FRAC-1:0] dv_quo [0:DIST_FRAC];
   tfs_info_type         dv_info [0:DIST_FRAC];
   logic                 pw_ready, pw_valid, ap_ready;
   logic [STEP_W-1:0]    pw_ox, pw_oy;
   tfs_info_type         pw_info;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_EFFECT_MODE: cfg_in.effect_mode = csr_wdata[MODE_W-1:0];
            CSR_GRID_WIDTH:  cfg_in.grid_width  = csr_wdata[GRID_DIM_W-1:0];
            CSR_GRID_HEIGHT: cfg_in.grid_height = csr_wdata[GRID_DIM_W-1:0];
            CSR_STEP_X:      cfg_in.step_x      = csr_wdata[STEP_W-1:0];
            CSR_STEP_Y:      cfg_in.step_y      = csr_wdata[STEP_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.effect_mode <= MODE_TOP_RIGHT;
         cfg_ff.grid_width  <= GRID_DIM_W'(1);
         cfg_ff.grid_height <= GRID_DIM_W'(1);
         cfg_ff.step_x      <= '0;
         cfg_ff.step_y      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = !front_ready;

   // Ratio terms and classification.
   tfs_front #(
      .GRID_BITS     (GRID_BITS),
      .PROGRESS_FRAC (PROGRESS_FRAC),
      .NUM_W         (NUM_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (dv_valid[0]),
      .out_ready (dv_ready[0]),
      .out_num   (dv_rem[0]),
      .out_den   (dv_den[0]),
      .out_info  (dv_info[0])
   );

   assign dv_quo[0] = '0;

   // Divider: one quotient bit per stage.
   for (genvar k = 0; k < DIST_FRAC; k++) begin : g_div
      tfs_div_step #(
         .NUM_W (NUM_W)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[k]),
         .in_ready  (dv_ready[k]),
         .in_rem    (dv_rem[k]),
         .in_den    (dv_den[k]),
         .in_quo    (dv_quo[k]),
         .in_info   (dv_info[k]),
         .out_valid (dv_valid[k+1]),
         .out_ready (dv_ready[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_den   (dv_den[k+1]),
         .out_quo   (dv_quo[k+1]),
         .out_info  (dv_info[k+1])
      );
   end

   assign dv_ready[DIST_FRAC] = pw_ready;

   // Distance and offsets.
   tfs_power u_power (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (dv_valid[DIST_FRAC]),
      .in_ready  (pw_ready),
      .in_quo    (dv_quo[DIST_FRAC]),
      .in_info   (dv_info[DIST_FRAC]),
      .out_valid (pw_valid),
      .out_ready (ap_ready),
      .out_ox    (pw_ox),
      .out_oy    (pw_oy),
      .out_info  (pw_info)
   );

   // Corner update and result register.
   tfs_apply u_apply (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pw_valid),
      .in_ready  (ap_ready),
      .in_ox     (pw_ox),
      .in_oy     (pw_oy),
      .in_info   (pw_info),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // With the result register empty every stage can advance, so input is open.
   a_open_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while the result register is empty");
`endif

endmodule

`default_nettype wire

// ===== test/tb_tile_fade_shrink.sv =====
// Self-checking testbench for tile_fade_shrink: table-driven and random tiles, scoreboarded.
`timescale 1ns / 1ps

module tb_tile_fade_shrink;
   import tfs_pkg::*;

   localparam int     CYCLE_LIMIT  = 200000;
   localparam int     DRAIN_CYCLES = 40;
   localparam int     HOLD_CYCLES  = 400;
   localparam int     PHASES       = 12;
   localparam int     PHASE_TILES  = 54;
   localparam longint CMAX         = 8388607;
   localparam longint CMIN         = -8388608;
   localparam int     UNITY        = 1 << PROGRESS_FRAC_DEF;

   // Clock and DUT ports; every input starts at a known value.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   tfs_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   tfs_rsp_type           rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_EFFECT_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // One row of the directed table: settings, tile and, where obvious, the result.
   typedef struct packed {
      tfs_cfg_type cfg;
      tfs_req_type req;
      logic        known;
      tfs_rsp_type rsp;
   } tile_case_type;

   tile_case_type tile_cases[$];
   tfs_rsp_type   expected_tiles[$];
   tfs_cfg_type   cfg_now;

   string corner_names [8] = '{"out_tr_y", "out_tr_x", "out_tl_y", "out_tl_x",
                               "out_br_y", "out_br_x", "out_bl_y", "out_bl_x"};

   int   fail_count   = 0;
   int   cycle_count  = 0;
   int   tiles_sent   = 0;
   int   config_count = 0;
   int   tiles_off    = 0;
   int   tiles_shrunk = 0;
   int   tiles_kept   = 0;
   int   hold_left    = 0;
   logic hold_armed   = 1'b0;
   logic quiet        = 1'b0;

   tile_fade_shrink u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Saturate a wide coordinate to the signed Q16.8 range.
   function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
      if (v > CMAX) begin
         return COORD_W'(CMAX);
      end
      if (v < CMIN) begin
         return COORD_W'(CMIN);
      end
      return COORD_W'(v);
   endfunction

   function automatic tfs_cfg_type make_cfg(input logic [MODE_W-1:0] mode, input int w,
                                            input int h, input int sx, input int sy);
      tfs_cfg_type c;
      c.effect_mode = mode;
      c.grid_width  = GRID_DIM_W'(w);
      c.grid_height = GRID_DIM_W'(h);
      c.step_x      = STEP_W'(sx);
      c.step_y      = STEP_W'(sy);
      return c;
   endfunction

   // Axis-aligned tile spanning (lx,ly) to (hx,hy).
   function automatic tfs_req_type make_tile(input int col, input int row, input int prog,
                                             input longint lx, input longint ly,
                                             input longint hx, input longint hy);
      tfs_req_type t;
      t.tile_col = TILE_IDX_W'(col);
      t.tile_row = TILE_IDX_W'(row);
      t.progress = PROGRESS_W'(prog);
      t.bl_x = COORD_W'(lx);
      t.bl_y = COORD_W'(ly);
      t.br_x = COORD_W'(hx);
      t.br_y = COORD_W'(ly);
      t.tl_x = COORD_W'(lx);
      t.tl_y = COORD_W'(hy);
      t.tr_x = COORD_W'(hx);
      t.tr_y = COORD_W'(hy);
      return t;
   endfunction

   // Result that carries the tile's own corners with the given state.
   function automatic tfs_rsp_type keep_corners(input logic [STATE_W-1:0] state,
                                                input tfs_req_type t);
      tfs_rsp_type o;
      o.tile_state = state;
      o.out_bl_x = t.bl_x;
      o.out_bl_y = t.bl_y;
      o.out_br_x = t.br_x;
      o.out_br_y = t.br_y;
      o.out_tl_x = t.tl_x;
      o.out_tl_y = t.tl_y;
      o.out_tr_x = t.tr_x;
      o.out_tr_y = t.tr_y;
      return o;
   endfunction

   // Expected result of one tile under the given register settings.
   function automatic tfs_rsp_type predict_tile(input tfs_cfg_type c, input tfs_req_type t);
      longint unsigned unity, prog, span, height, place, num, den;
      longint unsigned ratio, r2, r3, distance, rest;
      longint          dx, dy;
      tfs_rsp_type     o;
      unity  = 64'(UNITY);
      prog   = 64'(t.progress);
      span   = 64'(c.grid_width) + 64'(c.grid_height);
      height = 64'(c.grid_height);
      place  = 64'(t.tile_col) + 64'(t.tile_row);
      if (prog > unity) begin
         prog = unity;
      end
      case (c.effect_mode)
         MODE_TOP_RIGHT: begin
            num = place << PROGRESS_FRAC_DEF;
            den = span * prog;
         end
         MODE_BOTTOM_LEFT: begin
            num = span * (unity - prog);
            den = place << PROGRESS_FRAC_DEF;
         end
         MODE_UP: begin
            num = 64'(t.tile_row) << PROGRESS_FRAC_DEF;
            den = height * prog;
         end
         default: begin
            num = height * (unity - prog);
            den = 64'(t.tile_row) << PROGRESS_FRAC_DEF;
         end
      endcase

      // The front has not reached the tile at all: it vanishes.
      if (den != 0 && num == 0) begin
         o = '0;
         o.tile_state = TILE_OFF;
         return o;
      end
      // Degenerate front or ratio saturated at one: the tile is untouched.
      if (den == 0 || num >= den) begin
         return keep_corners(TILE_ORIGINAL, t);
      end

      // Distance is the ratio to the sixth power, all in Q0.16.
      ratio    = (num << DIST_FRAC) / den;
      r2       = (ratio * ratio) >> DIST_FRAC;
      r3       = (r2 * ratio) >> DIST_FRAC;
      distance = (r3 * r3) >> DIST_FRAC;
      rest     = (64'd1 << DIST_FRAC) - distance;
      dx    = longint'((64'(c.step_x) * rest) >> (DIST_FRAC + 1));
      dy    = longint'((64'(c.step_y) * rest) >> (DIST_FRAC + 1));
      if (c.effect_mode == MODE_UP || c.effect_mode == MODE_DOWN) begin
         dx = 0;
      end
      o.tile_state = TILE_SHRUNK;
      o.out_bl_x = clamp_coord(longint'(t.bl_x) + dx);
      o.out_bl_y = clamp_coord(longint'(t.bl_y) + dy);
      o.out_br_x = clamp_coord(longint'(t.br_x) - dx);
      o.out_br_y = clamp_coord(longint'(t.br_y) + dy);
      o.out_tl_x = clamp_coord(longint'(t.tl_x) + dx);
      o.out_tl_y = clamp_coord(longint'(t.tl_y) - dy);
      o.out_tr_x = clamp_coord(longint'(t.tr_x) - dx);
      o.out_tr_y = clamp_coord(longint'(t.tr_y) - dy);
      return o;
   endfunction

   task automatic add_case(input tfs_cfg_type c, input tfs_req_type t, input logic known,
                           input tfs_rsp_type r);
      tile_case_type tc;
      tc.cfg   = c;
      tc.req   = t;
      tc.known = known;
      tc.rsp   = r;
      tile_cases.push_back(tc);
   endtask

   // Offer one tile, with a random gap first, and record its expected result on transfer.
   task automatic send_tile(input tfs_req_type t, input logic known,
                            input tfs_rsp_type typed_rsp);
      while (!quiet && $urandom_range(99, 0) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do begin
         @(posedge clock);
      end while (req_stall);
      expected_tiles.push_back(known ? typed_rsp : predict_tile(cfg_now, t));
      tiles_sent++;
      @(negedge clock);
   endtask

   // Register write; bits above the register's width carry random junk.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value, input int width);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom()) << width;
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value | junk;
      @(negedge clock);
   endtask

   // Let the pipeline drain, then rewrite every register.
   task automatic apply_config(input tfs_cfg_type c);
      req_valid <= 1'b0;
      while (expected_tiles.size() != 0) begin
         @(negedge clock);
      end
      write_reg(CSR_EFFECT_MODE, CSR_DATA_W'(c.effect_mode), MODE_W);
      write_reg(CSR_GRID_WIDTH, CSR_DATA_W'(c.grid_width), GRID_DIM_W);
      write_reg(CSR_GRID_HEIGHT, CSR_DATA_W'(c.grid_height), GRID_DIM_W);
      write_reg(CSR_STEP_X, CSR_DATA_W'(c.step_x), STEP_W);
      write_reg(CSR_STEP_Y, CSR_DATA_W'(c.step_y), STEP_W);
      csr_write_en <= 1'b0;
      cfg_now = c;
      config_count++;
   endtask

   function automatic int pick_dim();
      case ($urandom_range(9, 0))
         0: return 0;
         1: return 511;
         2: return 256;
         3: return 1;
         4, 5: return int'($urandom_range(256, 1));
         default: return int'($urandom_range(16, 1));
      endcase
   endfunction

   function automatic int pick_step();
      case ($urandom_range(3, 0))
         0: return 0;
         1: return 23'h7FFFFF;
         2: return int'($urandom_range(16384, 0));
         default: return int'(STEP_W'($urandom()));
      endcase
   endfunction

   // Compare one result transfer with its expectation, field by field.
   task automatic check_tile(input tfs_rsp_type want, input tfs_rsp_type got);
      tfs_corners_type want_c, got_c;
      want_c = {want.out_bl_x, want.out_bl_y, want.out_br_x, want.out_br_y,
                want.out_tl_x, want.out_tl_y, want.out_tr_x, want.out_tr_y};
      got_c  = {got.out_bl_x, got.out_bl_y, got.out_br_x, got.out_br_y,
                got.out_tl_x, got.out_tl_y, got.out_tr_x, got.out_tr_y};
      if (got.tile_state !== want.tile_state) begin
         $error("tile_state: expected %0d, got %0d", want.tile_state, got.tile_state);
         fail_count++;
      end
      for (int i = 0; i < NUM_CORNERS; i++) begin
         if (got_c[i] !== want_c[i]) begin
            $error("%s: expected %0d, got %0d", corner_names[i],
                   $signed(want_c[i]), $signed(got_c[i]));
            fail_count++;
         end
      end
   endtask

   // Result monitor: every result transfer is matched against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tiles.size() == 0) begin
            $error("tile result with no tile outstanding: tile_state %0d",
                   rsp_data.tile_state);
            fail_count++;
         end else begin
            check_tile(expected_tiles.pop_front(), rsp_data);
         end
         case (rsp_data.tile_state)
            TILE_OFF: tiles_off++;
            TILE_SHRUNK: tiles_shrunk++;
            default: tiles_kept++;
         endcase
      end
   end

   // Receiver back-pressure: random stalls, one long hold-off, a quiet stretch.
   always @(negedge clock) begin
      if (hold_armed) begin
         hold_armed = 1'b0;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99, 0) < 12);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_tile_fade_shrink NOT OK");
         $finish;
      end
   end

   // Stimulus.
   initial begin
      tfs_req_type t;
      tfs_cfg_type c_rst, c_a, c_b, c_c, c_d, c_e, c_f;
      int          col, row, prog, w_lim, h_lim;
      longint      lo_x, lo_y, size_x, size_y;

      c_rst   = make_cfg(MODE_TOP_RIGHT, 1, 1, 0, 0);
      cfg_now = c_rst;
      c_a = make_cfg(MODE_TOP_RIGHT, 16, 16, 23'h7FFFFF, 23'h7FFFFF);
      c_b = make_cfg(MODE_BOTTOM_LEFT, 8, 8, 256, 256);
      c_c = make_cfg(MODE_UP, 4, 0, 256, 256);
      c_d = make_cfg(MODE_UP, 4, 10, 23'h7FFFFF, 23'h1000);
      c_e = make_cfg(MODE_DOWN, 511, 511, 0, 23'h7FFFFF);
      c_f = make_cfg(MODE_BOTTOM_LEFT, 256, 256, 23'h7FFFFF, 0);

      // Reset settings: no progress leaves the tile, the corner tile vanishes,
      // progress above one clamps, and a zero step shrinks by nothing.
      t = make_tile(0, 0, 0, CMIN, CMIN, CMAX, CMAX);
      add_case(c_rst, t, 1'b1, keep_corners(TILE_ORIGINAL, t));
      t = make_tile(0, 0, UNITY, -256, -256, 256, 256);
      add_case(c_rst, t, 1'b1, '0);
      t = make_tile(255, 255, 131071, CMAX, CMAX, CMIN, CMIN);
      add_case(c_rst, t, 1'b1, keep_corners(TILE_ORIGINAL, t));
      t = make_tile(0, 1, UNITY, 1000, 2000, 3000, 4000);
      add_case(c_rst, t, 1'b1, keep_corners(TILE_SHRUNK, t));
      // Full steps push corners past both coordinate limits.
      add_case(c_a, make_tile(3, 4, 40000, CMAX - 10, CMAX - 10, CMAX, CMAX), 1'b0, '0);
      add_case(c_a, make_tile(1, 0, UNITY, CMIN, CMIN, CMIN + 10, CMIN + 10), 1'b0, '0);
      // Bottom-left: origin tile has a zero divisor, full progress turns tiles off.
      t = make_tile(0, 0, 20000, 0, 0, 256, 256);
      add_case(c_b, t, 1'b1, keep_corners(TILE_ORIGINAL, t));
      add_case(c_b, make_tile(2, 3, UNITY, 0, 0, 256, 256), 1'b1, '0);
      add_case(c_b, make_tile(5, 5, 30000, -512, -512, -256, -256), 1'b0, '0);
      add_case(c_b, make_tile(200, 200, 0, 4096, 4096, 8192, 8192), 1'b0, '0);
      // Up with zero grid height: the divisor is zero.
      t = make_tile(1, 3, UNITY, 100, 100, 900, 900);
      add_case(c_c, t, 1'b1, keep_corners(TILE_ORIGINAL, t));
      // Up: bottom row vanishes, middle rows shrink on y only, rows beyond stay.
      add_case(c_d, make_tile(7, 0, 5000, 0, 0, 512, 512), 1'b1, '0);
      add_case(c_d, make_tile(7, 5, UNITY, -700, -700, 700, 700), 1'b0, '0);
      t = make_tile(0, 255, UNITY, -5, -5, 5, 5);
      add_case(c_d, t, 1'b1, keep_corners(TILE_ORIGINAL, t));
      // Down on the largest grid the registers hold.
      t = make_tile(9, 0, 30000, 300, 300, 600, 600);
      add_case(c_e, t, 1'b1, keep_corners(TILE_ORIGINAL, t));
      add_case(c_e, make_tile(9, 100, UNITY, 300, 300, 600, 600), 1'b1, '0);
      add_case(c_e, make_tile(0, 255, 1, CMIN, CMIN, CMAX, CMAX), 1'b0, '0);
      add_case(c_e, make_tile(0, 255, 50000, CMIN, CMIN, CMAX, CMAX), 1'b0, '0);
      add_case(c_e, make_tile(255, 1, 0, -1, -1, 1, 1), 1'b0, '0);
      add_case(c_f, make_tile(255, 255, 65535, CMIN, CMAX, CMAX, CMIN), 1'b0, '0);

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table.
      foreach (tile_cases[i]) begin
         if (tile_cases[i].cfg != cfg_now) begin
            apply_config(tile_cases[i].cfg);
         end
         send_tile(tile_cases[i].req, tile_cases[i].known, tile_cases[i].rsp);
      end

      // Random phases, each under fresh settings; modes rotate so each gets several.
      for (int phase = 0; phase < PHASES; phase++) begin
         apply_config(make_cfg(MODE_W'(phase % 4), pick_dim(), pick_dim(),
                               pick_step(), pick_step()));
         quiet = (phase == 5);
         if (phase == 3) begin
            hold_armed = 1'b1;
         end
         w_lim = (cfg_now.grid_width == 0) ? 1 :
                 (cfg_now.grid_width > 256) ? 256 : int'(cfg_now.grid_width);
         h_lim = (cfg_now.grid_height == 0) ? 1 :
                 (cfg_now.grid_height > 256) ? 256 : int'(cfg_now.grid_height);
         repeat (PHASE_TILES) begin
            // Mostly tiles inside the grid with progress up to one; the rest anything.
            if ($urandom_range(99, 0) < 80) begin
               col  = int'($urandom_range(w_lim - 1, 0));
               row  = int'($urandom_range(h_lim - 1, 0));
               prog = int'($urandom_range(UNITY, 0));
            end else begin
               col  = int'($urandom_range(255, 0));
               row  = int'($urandom_range(255, 0));
               prog = int'($urandom_range(131071, 0));
            end
            if ($urandom_range(9, 0) == 0) begin
               prog = ($urandom_range(1, 0) == 1) ? UNITY : 0;
            end
            lo_x   = longint'($signed(COORD_W'($urandom())));
            lo_y   = longint'($signed(COORD_W'($urandom())));
            size_x = ($urandom_range(1, 0) == 1) ? longint'(cfg_now.step_x)
                                                 : longint'($urandom_range(65535, 0));
            size_y = ($urandom_range(1, 0) == 1) ? longint'(cfg_now.step_y)
                                                 : longint'($urandom_range(65535, 0));
            t = make_tile(col, row, prog, lo_x, lo_y,
                          longint'(clamp_coord(lo_x + size_x)),
                          longint'(clamp_coord(lo_y + size_y)));
            if ($urandom_range(3, 0) == 0) begin
               t.bl_x = COORD_W'($urandom());
               t.bl_y = COORD_W'($urandom());
               t.br_x = COORD_W'($urandom());
               t.br_y = COORD_W'($urandom());
               t.tl_x = COORD_W'($urandom());
               t.tl_y = COORD_W'($urandom());
               t.tr_x = COORD_W'($urandom());
               t.tr_y = COORD_W'($urandom());
            end
            send_tile(t, 1'b0, '0);
         end
      end

      // Drain, then watch a little longer for stray results.
      req_valid <= 1'b0;
      quiet = 1'b0;
      while (expected_tiles.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d tiles under %0d register settings in all four modes.",
               tiles_sent, config_count + 1);
      $display("Results: %0d off, %0d shrunk, %0d original; one long receiver hold-off.",
               tiles_off, tiles_shrunk, tiles_kept);
      if (fail_count == 0) begin
         $display("tb_tile_fade_shrink OK");
      end else begin
         $display("tb_tile_fade_shrink NOT OK");
      end
      $finish;
   end

endmodule
